@@ sv/ulsw_pkg.sv @@
`timescale 1ns / 1ps
// Package for the UART link sleep/wake handshake block: item structs, action and
// flag codes, power command codes, register indexes and reset values.
// Depends on nothing.
package ulsw_pkg;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_TX_BEFORE = 3'd1,
        ACT_TX_AFTER  = 3'd2,
        ACT_WAKE_IRQ  = 3'd3,
        ACT_WAKE_RSP  = 3'd4,
        ACT_ENABLE    = 3'd5,
        ACT_DISABLE   = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        FLAG_NORMAL     = 2'd0,
        FLAG_SLEEP_ACK  = 2'd1,
        FLAG_WAKE_ACK   = 2'd2,
        FLAG_SLEEP_IND  = 2'd3
    } tx_flag_t;

    typedef enum logic [1:0] {
        PWR_NONE = 2'd0,
        PWR_UP   = 2'd1,
        PWR_DOWN = 2'd2
    } pwr_cmd_t;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TIMEOUT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HS_TIMEOUT   = 1'd1;

    localparam logic [CFG_DATA_W-1:0] IDLE_TIMEOUT_RESET = 16'd2000;
    localparam logic [CFG_DATA_W-1:0] HS_TIMEOUT_RESET   = 16'd1000;

    typedef struct packed {
        logic [2:0] action;
        logic [1:0] tx_flag;
        logic       power_change_fails;
        logic       sleep_send_fails;
    } in_item_t;

    typedef struct packed {
        logic       wake_line;
        logic [1:0] uart_power_cmd;
        logic       send_wake_response;
        logic       send_sleep_request;
        logic       tx_grant;
        logic       handshake_timed_out;
        logic       local_powered;
        logic       peer_awake;
        logic       enabled_status;
    } out_item_t;

    typedef struct packed {
        logic enabled;
        logic local_on;
        logic remote_awake;
        logic wake_level;
        logic handshake_pending;
        logic idle_armed;
    } link_flags_t;

endpackage

@@ sv/ulsw_step.sv @@
`timescale 1ns / 1ps
// Combinational next-state and result logic for one item of the link power manager.
// Depends on ulsw_pkg.
module ulsw_step #(
    parameter int TIMER_WIDTH = 16
) (
    input  ulsw_pkg::in_item_t            item,
    input  ulsw_pkg::link_flags_t         flags,
    input  logic [TIMER_WIDTH-1:0]        hs_count,
    input  logic [TIMER_WIDTH-1:0]        idle_count,
    input  logic [ulsw_pkg::CFG_DATA_W-1:0] idle_timeout,
    input  logic [ulsw_pkg::CFG_DATA_W-1:0] hs_timeout,
    output ulsw_pkg::link_flags_t         flags_next,
    output logic [TIMER_WIDTH-1:0]        hs_count_next,
    output logic [TIMER_WIDTH-1:0]        idle_count_next,
    output ulsw_pkg::out_item_t           result
);

    localparam int LW = (TIMER_WIDTH > ulsw_pkg::CFG_DATA_W) ? TIMER_WIDTH
                                                             : ulsw_pkg::CFG_DATA_W;
    localparam logic [TIMER_WIDTH-1:0] TMAX = '1;
    localparam logic [TIMER_WIDTH-1:0] TONE = TIMER_WIDTH'(1);

    logic [LW-1:0]          idle_ext;
    logic [LW-1:0]          hs_ext;
    logic [TIMER_WIDTH-1:0] idle_limit;
    logic [TIMER_WIDTH-1:0] hs_limit;
    logic [TIMER_WIDTH-1:0] hs_inc;
    logic [TIMER_WIDTH-1:0] idle_inc;
    logic [1:0]             pwr;
    logic                   want_on;
    logic                   do_power;

    always_comb begin
        idle_ext = LW'(idle_timeout);
        hs_ext   = LW'(hs_timeout);
        if (idle_timeout == '0) begin
            idle_limit = TONE;
        end else if (idle_ext > LW'(TMAX)) begin
            idle_limit = TMAX;
        end else begin
            idle_limit = TIMER_WIDTH'(idle_ext);
        end
        if (hs_timeout == '0) begin
            hs_limit = TONE;
        end else if (hs_ext > LW'(TMAX)) begin
            hs_limit = TMAX;
        end else begin
            hs_limit = TIMER_WIDTH'(hs_ext);
        end
        hs_inc   = (hs_count < TMAX) ? hs_count + TONE : hs_count;
        idle_inc = (idle_count < TMAX) ? idle_count + TONE : idle_count;
    end

    always_comb begin
        flags_next      = flags;
        hs_count_next   = hs_count;
        idle_count_next = idle_count;
        result          = '0;
        want_on         = 1'b0;
        do_power        = 1'b0;
        pwr             = ulsw_pkg::PWR_NONE;

        unique case (item.action) inside
            ulsw_pkg::ACT_TICK: begin
                if (flags.handshake_pending) begin
                    hs_count_next = hs_inc;
                    if (hs_inc >= hs_limit) begin
                        flags_next.handshake_pending = 1'b0;
                        flags_next.wake_level        = 1'b0;
                        result.tx_grant              = 1'b1;
                        result.handshake_timed_out   = 1'b1;
                    end
                end else if (flags.idle_armed) begin
                    idle_count_next = idle_inc;
                    if (idle_inc >= idle_limit) begin
                        flags_next.idle_armed = 1'b0;
                        if (flags.enabled) begin
                            if (!flags.remote_awake) begin
                                want_on  = 1'b0;
                                do_power = 1'b1;
                            end else begin
                                result.send_sleep_request = 1'b1;
                                if (item.sleep_send_fails) begin
                                    flags_next.idle_armed = 1'b1;
                                    idle_count_next       = '0;
                                end
                            end
                        end
                    end
                end
            end
            ulsw_pkg::ACT_TX_BEFORE: begin
                if (!flags.enabled) begin
                    result.tx_grant = 1'b1;
                end else if (!flags.handshake_pending) begin
                    if (item.tx_flag == ulsw_pkg::FLAG_SLEEP_ACK) begin
                        flags_next.remote_awake = 1'b0;
                        result.tx_grant         = 1'b1;
                    end else begin
                        want_on  = 1'b1;
                        do_power = 1'b1;
                        if (item.tx_flag == ulsw_pkg::FLAG_WAKE_ACK ||
                            flags.remote_awake) begin
                            flags_next.remote_awake = 1'b1;
                            result.tx_grant         = 1'b1;
                        end else begin
                            flags_next.wake_level        = 1'b1;
                            flags_next.handshake_pending = 1'b1;
                            hs_count_next                = '0;
                        end
                    end
                end
            end
            ulsw_pkg::ACT_TX_AFTER: begin
                if (flags.enabled && !flags.handshake_pending) begin
                    if (item.tx_flag == ulsw_pkg::FLAG_SLEEP_IND) begin
                        flags_next.remote_awake = 1'b0;
                    end
                    flags_next.idle_armed = 1'b1;
                    idle_count_next       = '0;
                end
            end
            ulsw_pkg::ACT_WAKE_IRQ,
            ulsw_pkg::ACT_WAKE_RSP: begin
                if (flags.enabled) begin
                    flags_next.remote_awake      = 1'b1;
                    flags_next.wake_level        = 1'b0;
                    flags_next.handshake_pending = 1'b0;
                    result.tx_grant              = flags.handshake_pending;
                    if (item.action == ulsw_pkg::ACT_WAKE_IRQ) begin
                        result.send_wake_response = 1'b1;
                        flags_next.idle_armed     = 1'b1;
                        idle_count_next           = '0;
                    end
                end
            end
            ulsw_pkg::ACT_ENABLE: begin
                want_on                 = 1'b1;
                do_power                = 1'b1;
                flags_next.remote_awake = 1'b1;
                flags_next.enabled      = 1'b1;
            end
            ulsw_pkg::ACT_DISABLE: begin
                flags_next.enabled           = 1'b0;
                flags_next.handshake_pending = 1'b0;
                result.tx_grant              = flags.handshake_pending;
            end
            default: begin
            end
        endcase

        if (do_power && (flags.local_on != want_on)) begin
            pwr = want_on ? ulsw_pkg::PWR_UP : ulsw_pkg::PWR_DOWN;
            if (!item.power_change_fails) begin
                flags_next.local_on = want_on;
            end
        end

        result.uart_power_cmd = pwr;
        result.wake_line      = flags_next.wake_level;
        result.local_powered  = flags_next.local_on;
        result.peer_awake     = flags_next.remote_awake;
        result.enabled_status = flags_next.enabled;
    end

endmodule

@@ sv/uart_link_sleep_wake_handshake_top.sv @@
`timescale 1ns / 1ps
// UART link power manager: one result item for every input item. An item is
// taken in every cycle while the result register is empty or being drained, and
// its result appears in the cycle after acceptance, held in the result register
// until taken; a new item cannot enter while a finished result waits undrained.
// The two timeout registers are written through a plain write port and read as
// one tick minimum, clipped to the largest value of a TIMER_WIDTH counter.
// Depends on ulsw_pkg and ulsw_step.
module uart_link_sleep_wake_handshake_top #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ulsw_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ulsw_pkg::out_item_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [ulsw_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  logic [ulsw_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    ulsw_pkg::link_flags_t             flags_reg;
    ulsw_pkg::link_flags_t             flags_next;
    logic [TIMER_WIDTH-1:0]            hs_count_reg;
    logic [TIMER_WIDTH-1:0]            hs_count_next;
    logic [TIMER_WIDTH-1:0]            idle_count_reg;
    logic [TIMER_WIDTH-1:0]            idle_count_next;
    logic [ulsw_pkg::CFG_DATA_W-1:0]   idle_timeout_reg;
    logic [ulsw_pkg::CFG_DATA_W-1:0]   hs_timeout_reg;
    ulsw_pkg::out_item_t               result_next;
    ulsw_pkg::out_item_t               result_reg;
    logic                              out_valid_reg;
    logic                              accept;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = result_reg;

    ulsw_step #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_step (
        .item            (s_data),
        .flags           (flags_reg),
        .hs_count        (hs_count_reg),
        .idle_count      (idle_count_reg),
        .idle_timeout    (idle_timeout_reg),
        .hs_timeout      (hs_timeout_reg),
        .flags_next      (flags_next),
        .hs_count_next   (hs_count_next),
        .idle_count_next (idle_count_next),
        .result          (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_timeout_reg <= ulsw_pkg::IDLE_TIMEOUT_RESET;
            hs_timeout_reg   <= ulsw_pkg::HS_TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                ulsw_pkg::CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_wr_data;
                ulsw_pkg::CFG_HS_TIMEOUT:   hs_timeout_reg   <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg      <= '0;
            hs_count_reg   <= '0;
            idle_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                flags_reg      <= flags_next;
                hs_count_reg   <= hs_count_next;
                idle_count_reg <= idle_count_next;
                out_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

endmodule

@@ tb/tb_uart_link_sleep_wake_handshake_top.sv @@
`timescale 1ns / 1ps
// Testbench for the UART link sleep/wake power manager: a directed table, then random
// phases under several timeout settings, checked against a cycle-free predictor or, for typed rows, a fixed status.
// Depends on ulsw_pkg and uart_link_sleep_wake_handshake_top.
module tb_uart_link_sleep_wake_handshake_top;

    localparam logic [2:0]  ACT_UNUSED       = 3'd7;
    localparam logic [15:0] TIMER_MAX        = 16'hFFFF;
    localparam int          CYCLE_LIMIT      = 1000000;
    localparam int          PHASES           = 8;
    localparam int          ITEMS_PER_PHASE  = 205;
    localparam logic [15:0] PHASE_IDLE [0:PHASES-1] =
        '{16'd1, 16'd3, 16'd65535, 16'd0, 16'd6, 16'd65535, 16'd1, 16'd12};
    localparam logic [15:0] PHASE_HS [0:PHASES-1] =
        '{16'd1, 16'd2, 16'd65535, 16'd0, 16'd4, 16'd1, 16'd65535, 16'd9};

    typedef struct {
        ulsw_pkg::in_item_t  item;
        bit                  typed;
        ulsw_pkg::out_item_t status;
    } dir_row_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    ulsw_pkg::in_item_t                s_data;
    logic                              m_valid;
    logic                              m_ready;
    ulsw_pkg::out_item_t               m_data;
    logic                              cfg_wr_en;
    logic [ulsw_pkg::CFG_INDEX_W-1:0]  cfg_wr_index;
    logic [ulsw_pkg::CFG_DATA_W-1:0]   cfg_wr_data;

    // Side information that travels with the item on the input channel.
    bit                      row_typed;
    ulsw_pkg::out_item_t     row_status;

    ulsw_pkg::out_item_t     expected_status [$];
    dir_row_t                dir_rows [$];
    int                      errors;
    int                      cycle_count;
    bit                      steady;

    // Predictor state and configuration.
    logic                    p_enabled;
    logic                    p_local_on;
    logic                    p_remote_awake;
    logic                    p_wake_level;
    logic                    p_hs_pending;
    logic                    p_idle_armed;
    logic [15:0]             p_hs_count;
    logic [15:0]             p_idle_count;
    logic [15:0]             p_idle_to;
    logic [15:0]             p_hs_to;

    ulsw_pkg::out_item_t     want;
    ulsw_pkg::out_item_t     predicted;

    uart_link_sleep_wake_handshake_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [15:0] eff_timeout(logic [15:0] t);
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

    function automatic ulsw_pkg::pwr_cmd_t power_request(logic on, logic fails);
        if (p_local_on == on) return ulsw_pkg::PWR_NONE;
        if (!fails) p_local_on = on;
        return on ? ulsw_pkg::PWR_UP : ulsw_pkg::PWR_DOWN;
    endfunction

    function automatic logic mark_peer_awake();
        p_remote_awake = 1'b1;
        p_wake_level   = 1'b0;
        if (p_hs_pending) begin
            p_hs_pending = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void rearm_idle();
        p_idle_armed = 1'b1;
        p_idle_count = 16'd0;
    endfunction

    function automatic ulsw_pkg::out_item_t predict_link_status(ulsw_pkg::in_item_t it);
        ulsw_pkg::out_item_t r;
        r = '0;
        case (it.action)
            ulsw_pkg::ACT_TICK: begin
                if (p_hs_pending) begin
                    if (p_hs_count < TIMER_MAX) p_hs_count++;
                    if (p_hs_count >= eff_timeout(p_hs_to)) begin
                        p_hs_pending          = 1'b0;
                        p_wake_level          = 1'b0;
                        r.tx_grant            = 1'b1;
                        r.handshake_timed_out = 1'b1;
                    end
                end else if (p_idle_armed) begin
                    if (p_idle_count < TIMER_MAX) p_idle_count++;
                    if (p_idle_count >= eff_timeout(p_idle_to)) begin
                        p_idle_armed = 1'b0;
                        if (p_enabled) begin
                            if (!p_remote_awake) begin
                                r.uart_power_cmd = power_request(1'b0, it.power_change_fails);
                            end else begin
                                r.send_sleep_request = 1'b1;
                                if (it.sleep_send_fails) rearm_idle();
                            end
                        end
                    end
                end
            end
            ulsw_pkg::ACT_TX_BEFORE: begin
                if (!p_enabled) begin
                    r.tx_grant = 1'b1;
                end else if (!p_hs_pending) begin
                    if (it.tx_flag == ulsw_pkg::FLAG_SLEEP_ACK) begin
                        p_remote_awake = 1'b0;
                        r.tx_grant     = 1'b1;
                    end else begin
                        if (it.tx_flag == ulsw_pkg::FLAG_WAKE_ACK) p_remote_awake = 1'b1;
                        r.uart_power_cmd = power_request(1'b1, it.power_change_fails);
                        if (p_remote_awake) begin
                            r.tx_grant = 1'b1;
                        end else begin
                            p_wake_level = 1'b1;
                            p_hs_pending = 1'b1;
                            p_hs_count   = 16'd0;
                        end
                    end
                end
            end
            ulsw_pkg::ACT_TX_AFTER: begin
                if (p_enabled && !p_hs_pending) begin
                    if (it.tx_flag == ulsw_pkg::FLAG_SLEEP_IND) p_remote_awake = 1'b0;
                    rearm_idle();
                end
            end
            ulsw_pkg::ACT_WAKE_IRQ: begin
                if (p_enabled) begin
                    r.tx_grant           = mark_peer_awake();
                    r.send_wake_response = 1'b1;
                    rearm_idle();
                end
            end
            ulsw_pkg::ACT_WAKE_RSP: begin
                if (p_enabled) r.tx_grant = mark_peer_awake();
            end
            ulsw_pkg::ACT_ENABLE: begin
                r.uart_power_cmd = power_request(1'b1, it.power_change_fails);
                p_remote_awake   = 1'b1;
                p_enabled        = 1'b1;
            end
            ulsw_pkg::ACT_DISABLE: begin
                p_enabled = 1'b0;
                if (p_hs_pending) begin
                    p_hs_pending = 1'b0;
                    r.tx_grant   = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.wake_line      = p_wake_level;
        r.local_powered  = p_local_on;
        r.peer_awake     = p_remote_awake;
        r.enabled_status = p_enabled;
        return r;
    endfunction

    function automatic ulsw_pkg::out_item_t status_word(logic wake, ulsw_pkg::pwr_cmd_t pwr,
                                                        logic wrsp, logic sreq, logic grant,
                                                        logic tout, logic lcl, logic peer,
                                                        logic en);
        ulsw_pkg::out_item_t r;
        r.wake_line           = wake;
        r.uart_power_cmd      = pwr;
        r.send_wake_response  = wrsp;
        r.send_sleep_request  = sreq;
        r.tx_grant            = grant;
        r.handshake_timed_out = tout;
        r.local_powered       = lcl;
        r.peer_awake          = peer;
        r.enabled_status      = en;
        return r;
    endfunction

    function automatic ulsw_pkg::in_item_t random_item();
        ulsw_pkg::in_item_t it;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)      it.action = ulsw_pkg::ACT_TICK;
        else if (pick < 60) it.action = ulsw_pkg::ACT_TX_BEFORE;
        else if (pick < 74) it.action = ulsw_pkg::ACT_TX_AFTER;
        else if (pick < 80) it.action = ulsw_pkg::ACT_WAKE_IRQ;
        else if (pick < 88) it.action = ulsw_pkg::ACT_WAKE_RSP;
        else if (pick < 94) it.action = ulsw_pkg::ACT_ENABLE;
        else if (pick < 98) it.action = ulsw_pkg::ACT_DISABLE;
        else                it.action = ACT_UNUSED;
        it.tx_flag            = 2'($urandom_range(0, 3));
        it.power_change_fails = ($urandom_range(0, 4) == 0);
        it.sleep_send_fails   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_row(logic [2:0] act, logic [1:0] flag, logic pf, logic sf, bit typed,
                           ulsw_pkg::out_item_t status);
        dir_row_t row;
        row.item.action             = act;
        row.item.tx_flag            = flag;
        row.item.power_change_fails = pf;
        row.item.sleep_send_fails   = sf;
        row.typed                   = typed;
        row.status                  = status;
        dir_rows.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic drive_item(ulsw_pkg::in_item_t it, bit typed, ulsw_pkg::out_item_t status);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data     = it;
        row_typed  = typed;
        row_status = status;
        s_valid    = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(logic [ulsw_pkg::CFG_INDEX_W-1:0] idx,
                             logic [ulsw_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = data;
        if (idx == ulsw_pkg::CFG_IDLE_TIMEOUT) p_idle_to = data;
        else p_hs_to = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %p", $time, m_data);
                    errors++;
                end else begin
                    want = expected_status.pop_front();
                    if (m_data !== want) begin
                        $display("%0t: result mismatch: expected %p, actual %p",
                                 $time, want, m_data);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predicted = predict_link_status(s_data);
                expected_status.push_back(row_typed ? row_status : predicted);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_uart_link_sleep_wake_handshake_top: FAIL");
            $finish;
        end
    end

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            int gap;
            gap = pick_gap();
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(negedge aclk);
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_index   = '0;
        cfg_wr_data    = '0;
        row_typed      = 1'b0;
        row_status     = '0;
        errors         = 0;
        cycle_count    = 0;
        steady         = 1'b0;
        p_enabled      = 1'b0;
        p_local_on     = 1'b0;
        p_remote_awake = 1'b0;
        p_wake_level   = 1'b0;
        p_hs_pending   = 1'b0;
        p_idle_armed   = 1'b0;
        p_hs_count     = 16'd0;
        p_idle_count   = 16'd0;
        p_idle_to      = ulsw_pkg::IDLE_TIMEOUT_RESET;
        p_hs_to        = ulsw_pkg::HS_TIMEOUT_RESET;

        // Directed table. The handshake timeout of zero acts as one tick.
        add_row(ulsw_pkg::ACT_TICK, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b1,
                status_word(1'b0, ulsw_pkg::PWR_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                            1'b0));
        add_row(ulsw_pkg::ACT_TX_BEFORE, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b1,
                status_word(1'b0, ulsw_pkg::PWR_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                            1'b0));
        add_row(ulsw_pkg::ACT_TX_AFTER, ulsw_pkg::FLAG_SLEEP_IND, 1'b1, 1'b1, 1'b1,
                status_word(1'b0, ulsw_pkg::PWR_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                            1'b0));
        add_row(ulsw_pkg::ACT_WAKE_IRQ, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b1,
                status_word(1'b0, ulsw_pkg::PWR_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                            1'b0));
        add_row(ulsw_pkg::ACT_WAKE_RSP, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b1,
                status_word(1'b0, ulsw_pkg::PWR_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                            1'b0));
        add_row(ulsw_pkg::ACT_ENABLE, ulsw_pkg::FLAG_NORMAL, 1'b1, 1'b0, 1'b1,
                status_word(1'b0, ulsw_pkg::PWR_UP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                            1'b1));
        add_row(ulsw_pkg::ACT_ENABLE, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TX_BEFORE, ulsw_pkg::FLAG_SLEEP_ACK, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TX_BEFORE, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TX_AFTER, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TICK, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TX_BEFORE, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b1, 1'b0, '0);
        add_row(ulsw_pkg::ACT_WAKE_RSP, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TX_AFTER, ulsw_pkg::FLAG_SLEEP_IND, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TICK, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TICK, ulsw_pkg::FLAG_NORMAL, 1'b1, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TX_AFTER, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TX_BEFORE, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TICK, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TX_BEFORE, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_DISABLE, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TICK, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TICK, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_ENABLE, ulsw_pkg::FLAG_WAKE_ACK, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_WAKE_IRQ, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TICK, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(ulsw_pkg::ACT_TICK, ulsw_pkg::FLAG_NORMAL, 1'b0, 1'b1, 1'b0, '0);
        add_row(ACT_UNUSED, ulsw_pkg::FLAG_SLEEP_IND, 1'b1, 1'b1, 1'b0, '0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        write_reg(ulsw_pkg::CFG_IDLE_TIMEOUT, 16'd2);
        write_reg(ulsw_pkg::CFG_HS_TIMEOUT, 16'd0);
        foreach (dir_rows[i]) drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].status);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(ulsw_pkg::CFG_IDLE_TIMEOUT, PHASE_IDLE[p]);
            write_reg(ulsw_pkg::CFG_HS_TIMEOUT, PHASE_HS[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
                drive_item(random_item(), 1'b0, '0);
            end
            steady = 1'b0;
            drain_results();
        end

        if (errors == 0)
            $display("tb_uart_link_sleep_wake_handshake_top: PASS");
        else
            $display("tb_uart_link_sleep_wake_handshake_top: FAIL");
        $finish;
    end

endmodule
